// File: rtl/core/awb_pkg.sv
// ----------------------------------------------------------------------------
// awb_pkg: shared types and constants for the AWB gain normalizer
// Item structs, status codes, divider sizes and the saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none
package awb_pkg;

  localparam int DIV_NW = 25;   // dividend width of the divider pipeline
  localparam int DIV_DW = 16;   // divisor width

  localparam logic [15:0] UNITY_GAIN = 16'h0100;
  localparam logic [15:0] RATIO_ONE  = 16'd512;
  localparam logic [15:0] SAT16      = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MEAS_ZERO  = 2'd1,
    ST_RATIO_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] measured_rg;
    logic [15:0] measured_bg;
    logic [15:0] golden_rg;
    logic [15:0] golden_bg;
  } in_item_t;

  typedef struct packed {
    logic [15:0] red_gain;
    logic [15:0] green_gain;
    logic [15:0] blue_gain;
    status_t     status;
  } out_item_t;

  // Clamp a quotient to 16 bits
  function automatic logic [15:0] sat16(input logic [DIV_NW-1:0] v);
    logic [15:0] r;
    if (v[DIV_NW-1:16] != '0) r = SAT16;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/awb_div.sv
// ----------------------------------------------------------------------------
// awb_div: pipelined restoring divider
// One quotient bit per stage, DIV_NW stages, advances when en is high.
// ----------------------------------------------------------------------------
`default_nettype none
module awb_div
  import awb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [DIV_NW-1:0] num,
  input  wire logic [DIV_DW-1:0] den,
  output logic      [DIV_NW-1:0] quo
);

  logic [DIV_DW-1:0] rem_r [DIV_NW];
  logic [DIV_NW-1:0] num_r [DIV_NW];
  logic [DIV_DW-1:0] den_r [DIV_NW];
  logic [DIV_DW-1:0] rem_nxt [DIV_NW];
  logic [DIV_NW-1:0] num_nxt [DIV_NW];
  logic [DIV_DW-1:0] den_nxt [DIV_NW];

  // Compare-subtract per stage; quotient bits shift in at the bottom
  always_comb begin
    logic [DIV_DW-1:0] rem_in;
    logic [DIV_NW-1:0] num_in;
    logic [DIV_DW-1:0] den_in;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;
    for (int s = 0; s < DIV_NW; s++) begin
      if (s == 0) begin
        rem_in = '0;
        num_in = num;
        den_in = den;
      end else begin
        rem_in = rem_r[s-1];
        num_in = num_r[s-1];
        den_in = den_r[s-1];
      end
      trial = {rem_in, num_in[DIV_NW-1]};
      ge    = trial >= {1'b0, den_in};
      diff  = trial - {1'b0, den_in};
      rem_nxt[s] = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      num_nxt[s] = {num_in[DIV_NW-2:0], ge};
      den_nxt[s] = den_in;
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_NW; s++) begin
        rem_r[s] <= rem_nxt[s];
        num_r[s] <= num_nxt[s];
        den_r[s] <= den_nxt[s];
      end
    end
  end

  assign quo = num_r[DIV_NW-1];

endmodule
`default_nettype wire

// File: rtl/core/awb_channel_gain_normalizer.sv
// ----------------------------------------------------------------------------
// awb_channel_gain_normalizer: AWB channel gains from golden/measured ratios
// Two rounds of pipelined division, then gain selection and saturation.
// ----------------------------------------------------------------------------
// Accepts one ratio set per cycle while not stalled and passes each through
// 25 stages for the ratio division, one register for ratio saturation,
// 25 stages for the gain divisions and one output register. The whole
// pipeline stalls as a unit while the output register holds an untaken
// result, so throughput is one item per cycle whenever out_ready is high.
`default_nettype none
module awb_channel_gain_normalizer
  import awb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  typedef struct packed {
    logic valid;
    logic mz;
  } tag1_t;

  typedef struct packed {
    logic        valid;
    logic        mz;
    logic [15:0] rr;
    logic [15:0] br;
  } tag2_t;

  logic advance;
  logic out_valid_r;
  out_item_t out_data_r, out_nxt;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;

  // Round one: ratios 512*golden/measured
  logic [DIV_NW-1:0] q_rr, q_br;
  awb_div u_div_rr (.clk, .en(advance), .num({in_data.golden_rg, 9'b0}),
                    .den(in_data.measured_rg), .quo(q_rr));
  awb_div u_div_br (.clk, .en(advance), .num({in_data.golden_bg, 9'b0}),
                    .den(in_data.measured_bg), .quo(q_br));

  tag1_t t1_r [DIV_NW];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_NW; s++) t1_r[s] <= '0;
    end else if (advance) begin
      t1_r[0] <= '{valid: in_valid,
                   mz: (in_data.measured_rg == '0) || (in_data.measured_bg == '0)};
      for (int s = 1; s < DIV_NW; s++) t1_r[s] <= t1_r[s-1];
    end
  end

  // Saturate ratios
  tag2_t mid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r.valid <= 1'b0;
    end else if (advance) begin
      mid_r.valid <= t1_r[DIV_NW-1].valid;
    end
    if (advance) begin
      mid_r.mz <= t1_r[DIV_NW-1].mz;
      mid_r.rr <= sat16(q_rr);
      mid_r.br <= sat16(q_br);
    end
  end

  // Round two: the four candidate gains
  logic [DIV_NW-1:0] q_g_r, q_b_r, q_r_b, q_g_b;
  awb_div u_div_gr (.clk, .en(advance), .num(DIV_NW'(32'd131072)),
                    .den(mid_r.rr), .quo(q_g_r));
  awb_div u_div_bb (.clk, .en(advance), .num({1'b0, mid_r.br, 8'b0}),
                    .den(mid_r.rr), .quo(q_b_r));
  awb_div u_div_rb (.clk, .en(advance), .num({1'b0, mid_r.rr, 8'b0}),
                    .den(mid_r.br), .quo(q_r_b));
  awb_div u_div_gb (.clk, .en(advance), .num(DIV_NW'(32'd131072)),
                    .den(mid_r.br), .quo(q_g_b));

  tag2_t t2_r [DIV_NW];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_NW; s++) t2_r[s].valid <= 1'b0;
    end else if (advance) begin
      t2_r[0].valid <= mid_r.valid;
      for (int s = 1; s < DIV_NW; s++) t2_r[s].valid <= t2_r[s-1].valid;
    end
    if (advance) begin
      t2_r[0].mz <= mid_r.mz;
      t2_r[0].rr <= mid_r.rr;
      t2_r[0].br <= mid_r.br;
      for (int s = 1; s < DIV_NW; s++) begin
        t2_r[s].mz <= t2_r[s-1].mz;
        t2_r[s].rr <= t2_r[s-1].rr;
        t2_r[s].br <= t2_r[s-1].br;
      end
    end
  end

  // Select gains by ratio branch
  always_comb begin
    tag2_t t;
    logic  r_hi, b_hi, red_ref;
    t       = t2_r[DIV_NW-1];
    r_hi    = t.rr >= RATIO_ONE;
    b_hi    = t.br >= RATIO_ONE;
    red_ref = (!r_hi && b_hi) || (!r_hi && !b_hi && (q_g_r >= q_g_b));
    out_nxt = '{red_gain: UNITY_GAIN, green_gain: UNITY_GAIN,
                blue_gain: UNITY_GAIN, status: ST_OK};
    if (t.mz) begin
      out_nxt.status = ST_MEAS_ZERO;
    end else if ((t.rr == '0) || (t.br == '0)) begin
      out_nxt.status = ST_RATIO_ZERO;
    end else if (r_hi && b_hi) begin
      out_nxt.red_gain  = {1'b0, t.rr[15:1]};
      out_nxt.blue_gain = {1'b0, t.br[15:1]};
    end else if (red_ref) begin
      out_nxt.green_gain = sat16(q_g_r);
      out_nxt.blue_gain  = sat16(q_b_r);
    end else begin
      out_nxt.red_gain   = sat16(q_r_b);
      out_nxt.green_gain = sat16(q_g_b);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= t2_r[DIV_NW-1].valid;
    end
    if (advance) out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Error results carry unity gains
  a_err_unity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status != ST_OK) |->
      (out_data_r.red_gain == UNITY_GAIN) && (out_data_r.green_gain == UNITY_GAIN) &&
      (out_data_r.blue_gain == UNITY_GAIN))
    else $error("error status without unity gains");

  // Normal results have at least one gain at unity
  a_one_unity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status == ST_OK) |->
      (out_data_r.red_gain == UNITY_GAIN) || (out_data_r.green_gain == UNITY_GAIN) ||
      (out_data_r.blue_gain == UNITY_GAIN))
    else $error("no gain at unity");

  // Green never falls below unity
  a_green_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.green_gain >= UNITY_GAIN)
    else $error("green gain below unity");

endmodule
`default_nettype wire
